@@ hdl/wpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_pkg: shared types and constants
// Parse phases, status codes, tags and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package wpd_pkg;

    localparam int unsigned MAX_CHANNELS = 8;
    localparam int unsigned CH_W         = 5;  // holds 0..31
    localparam int unsigned SUM_W        = 20;

    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746d66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam logic [31:0] RATE_CD  = 32'd44100;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    localparam logic [1:0] ST_CD     = 2'd0;
    localparam logic [1:0] ST_OTHER  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_CHUNK_HDR,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_PAD,
        PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        CS_ACCEPT,
        CS_DIV,
        CS_OUT_SAMPLE,
        CS_OUT_STATUS
    } ctrl_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic step;       // apply accepted byte to parse state
        logic div_start;  // launch frame mean divide
        logic clear;      // return to reset state after end of file
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_done;  // accepted byte completed a frame
        logic div_busy;
    } dp_sts_t;

endpackage

@@ hdl/wpd_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_divider: signed frame-sum divider
// Restoring divide of the frame sum by the channel count, one quotient bit
// per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module wpd_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [wpd_pkg::SUM_W-1:0] dividend,
    input  logic [wpd_pkg::CH_W-1:0]  divisor,
    output logic                      busy,
    output logic signed [15:0]        quotient
);
    import wpd_pkg::*;

    localparam int unsigned CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CH_W-1:0]   rem_reg, rem_next;
    logic [CH_W-1:0]   den_reg, den_next;
    logic [CH_W:0]     trial;
    logic [SUM_W-1:0]  q_signed;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = CH_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CH_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign q_signed = neg_reg ? SUM_W'(-quo_reg) : quo_reg;
    assign quotient = q_signed[15:0];
    assign busy     = busy_reg;

endmodule

@@ hdl/wpd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_datapath: chunk walker and frame accumulator
// Holds parse state, fmt fields and the running frame sum; computes status.
// ----------------------------------------------------------------------------
module wpd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wpd_pkg::dp_cmd_t     cmd,
    output wpd_pkg::dp_sts_t     sts,
    input  logic [7:0]           data_byte,
    output logic signed [15:0]   mean,
    output logic [1:0]           status
);
    import wpd_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [31:0]  pos_reg, pos_next;
    logic [31:0]  tag_reg, tag_next;
    logic [31:0]  len_reg, len_next;
    logic [15:0]  fmt_reg, fmt_next;
    logic [15:0]  chn_reg, chn_next;
    logic [31:0]  rate_reg, rate_next;
    logic [15:0]  bits_reg, bits_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CH_W-1:0] cidx_reg, cidx_next;
    logic [7:0]   low_reg, low_next;
    logic         fl_fmt_reg, fl_fmt_next;
    logic         fl_data_reg, fl_data_next;
    logic         fl_fail_reg, fl_fail_next;
    logic signed [SUM_W-1:0] div_sum_reg, div_sum_next;
    logic         frame_done;
    logic         div_busy;

    logic [31:0]  tag_sh;
    logic [31:0]  len_sh;
    logic         body_end;
    logic signed [SUM_W-1:0] acc;

    assign tag_sh   = {data_byte, tag_reg[31:8]};
    assign body_end = (pos_reg + 32'd1) == len_reg;
    assign acc      = sum_reg + SUM_W'($signed({data_byte, low_reg}));
    assign len_sh   = len_reg | ({24'd0, data_byte} << {pos_reg[1:0], 3'b000});

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        fmt_next     = fmt_reg;
        chn_next     = chn_reg;
        rate_next    = rate_reg;
        bits_next    = bits_reg;
        sum_next     = sum_reg;
        cidx_next    = cidx_reg;
        low_next     = low_reg;
        fl_fmt_next  = fl_fmt_reg;
        fl_data_next = fl_data_reg;
        fl_fail_next = fl_fail_reg;
        div_sum_next = div_sum_reg;
        frame_done   = 1'b0;

        if (cmd.clear)
        begin
            phase_next   = PH_HEADER;
            pos_next     = '0;
            tag_next     = '0;
            len_next     = '0;
            fmt_next     = '0;
            chn_next     = '0;
            rate_next    = '0;
            bits_next    = '0;
            sum_next     = '0;
            cidx_next    = '0;
            low_next     = '0;
            fl_fmt_next  = 1'b0;
            fl_data_next = 1'b0;
            fl_fail_next = 1'b0;
        end
        else if (cmd.step)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    tag_next = tag_sh;
                    pos_next = pos_reg + 32'd1;
                    if (pos_reg == 32'd3 && tag_sh != TAG_RIFF)
                    begin
                        fl_fail_next = 1'b1;
                        phase_next   = PH_IDLE;
                        pos_next     = pos_reg;
                    end
                    else if (pos_reg == 32'd11)
                    begin
                        pos_next = pos_reg;
                        if (tag_sh != TAG_WAVE)
                        begin
                            fl_fail_next = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_CHUNK_HDR;
                            pos_next   = '0;
                            tag_next   = '0;
                        end
                    end
                end
                PH_CHUNK_HDR:
                begin
                    pos_next = pos_reg + 32'd1;
                    if (pos_reg < 32'd4)
                    begin
                        tag_next = tag_sh;
                        if (pos_reg == 32'd0)
                            len_next = '0;
                    end
                    else
                    begin
                        len_next = len_sh;
                    end
                    if (pos_reg == 32'd7)
                    begin
                        pos_next = '0;
                        // len_sh is the final length here
                        if (tag_reg == TAG_FMT)
                        begin
                            if (len_sh < FMT_MIN_LEN)
                            begin
                                fl_fail_next = 1'b1;
                                phase_next   = PH_IDLE;
                            end
                            else
                                phase_next = PH_FMT;
                        end
                        else if (tag_reg == TAG_DATA)
                        begin
                            if (!fl_fmt_reg)
                            begin
                                fl_fail_next = 1'b1;
                                phase_next   = PH_IDLE;
                            end
                            else if (len_sh == 32'd0)
                            begin
                                phase_next = PH_CHUNK_HDR;
                                tag_next   = '0;
                            end
                            else if (fmt_reg != 16'd1 || bits_reg != 16'd16 ||
                                     chn_reg == 16'd0 ||
                                     chn_reg > 16'(MAX_CHANNELS))
                            begin
                                fl_fail_next = 1'b1;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                fl_data_next = 1'b1;
                                sum_next     = '0;
                                cidx_next    = '0;
                                phase_next   = PH_DATA;
                            end
                        end
                        else if (len_sh == 32'd0)
                        begin
                            phase_next = PH_CHUNK_HDR;
                            tag_next   = '0;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                end
                PH_FMT, PH_SKIP:
                begin
                    if (phase_reg == PH_FMT)
                    begin
                        case (pos_reg)
                            32'd0:  fmt_next  = {8'd0, data_byte};
                            32'd1:  fmt_next  = {data_byte, fmt_reg[7:0]};
                            32'd2:  chn_next  = {8'd0, data_byte};
                            32'd3:  chn_next  = {data_byte, chn_reg[7:0]};
                            32'd4:  rate_next = {24'd0, data_byte};
                            32'd5:  rate_next[15:8]  = data_byte;
                            32'd6:  rate_next[23:16] = data_byte;
                            32'd7:  rate_next[31:24] = data_byte;
                            32'd14: bits_next = {8'd0, data_byte};
                            32'd15:
                            begin
                                bits_next   = {data_byte, bits_reg[7:0]};
                                fl_fmt_next = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    if (body_end)
                    begin
                        pos_next   = '0;
                        tag_next   = '0;
                        phase_next = len_reg[0] ? PH_PAD : PH_CHUNK_HDR;
                    end
                    else
                        pos_next = pos_reg + 32'd1;
                end
                PH_DATA:
                begin
                    if (!pos_reg[0])
                        low_next = data_byte;
                    else if (CH_W'(cidx_reg + 1'b1) >= CH_W'(chn_reg))
                    begin
                        frame_done   = 1'b1;
                        div_sum_next = acc;
                        sum_next     = '0;
                        cidx_next    = '0;
                    end
                    else
                    begin
                        sum_next  = acc;
                        cidx_next = cidx_reg + 1'b1;
                    end
                    if (body_end)
                    begin
                        phase_next = PH_IDLE;
                        pos_next   = '0;
                    end
                    else
                        pos_next = pos_reg + 32'd1;
                end
                PH_PAD:
                begin
                    phase_next = PH_CHUNK_HDR;
                    pos_next   = '0;
                    tag_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            tag_reg     <= '0;
            len_reg     <= '0;
            fmt_reg     <= '0;
            chn_reg     <= '0;
            rate_reg    <= '0;
            bits_reg    <= '0;
            sum_reg     <= '0;
            cidx_reg    <= '0;
            low_reg     <= '0;
            fl_fmt_reg  <= 1'b0;
            fl_data_reg <= 1'b0;
            fl_fail_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            fmt_reg     <= fmt_next;
            chn_reg     <= chn_next;
            rate_reg    <= rate_next;
            bits_reg    <= bits_next;
            sum_reg     <= sum_next;
            cidx_reg    <= cidx_next;
            low_reg     <= low_next;
            fl_fmt_reg  <= fl_fmt_next;
            fl_data_reg <= fl_data_next;
            fl_fail_reg <= fl_fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_sum_reg <= div_sum_next;
    end

    wpd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_sum_reg),
        .divisor  (chn_reg[CH_W-1:0]),
        .busy     (div_busy),
        .quotient (mean)
    );

    assign sts = '{frame_done: frame_done, div_busy: div_busy};

    always_comb
    begin
        if (fl_fail_reg || !fl_data_reg)
            status = ST_REJECT;
        else if (rate_reg == RATE_CD)
            status = ST_CD;
        else
            status = ST_OTHER;
    end

endmodule

@@ hdl/wpd_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_controller: byte sequencer
// Accepts one byte, waits on the divider for a finished frame, and presents
// the sample and/or status results in order.
// ----------------------------------------------------------------------------
module wpd_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_eof,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kind,
    output logic              out_last,
    output wpd_pkg::dp_cmd_t  cmd,
    input  wpd_pkg::dp_sts_t  sts
);
    import wpd_pkg::*;

    ctrl_t state_reg, state_next;
    logic  eof_reg, eof_next;
    logic  in_xfer;
    logic  out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        eof_next   = eof_reg;
        case (state_reg)
            CS_ACCEPT:
            begin
                if (in_xfer)
                begin
                    eof_next = in_eof;
                    if (sts.frame_done)
                        state_next = CS_DIV;
                    else if (in_eof)
                        state_next = CS_OUT_STATUS;
                end
            end
            CS_DIV:
                if (!sts.div_busy && !cmd.div_start)
                    state_next = CS_OUT_SAMPLE;
            CS_OUT_SAMPLE:
                if (out_xfer)
                    state_next = eof_reg ? CS_OUT_STATUS : CS_ACCEPT;
            CS_OUT_STATUS:
                if (out_xfer)
                    state_next = CS_ACCEPT;
            default:
                state_next = CS_ACCEPT;
        endcase
    end

    logic started_reg;

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        out_kind      = KIND_SAMPLE;
        out_last      = 1'b0;
        cmd.step      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.clear     = 1'b0;
        case (state_reg)
            CS_ACCEPT:
            begin
                in_ready = 1'b1;
                cmd.step = in_valid;
            end
            CS_DIV:
                cmd.div_start = !started_reg;
            CS_OUT_SAMPLE:
            begin
                out_valid = 1'b1;
                out_last  = !eof_reg;
            end
            CS_OUT_STATUS:
            begin
                out_valid = 1'b1;
                out_kind  = KIND_STATUS;
                out_last  = 1'b1;
                cmd.clear = out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CS_ACCEPT;
            eof_reg     <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            eof_reg     <= eof_next;
            started_reg <= (state_reg == CS_DIV);
        end
    end

endmodule

@@ hdl/wav_pcm16_parse_downmix_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm16_parse_downmix_unit: RIFF/WAVE PCM16 parser with mono downmix
// A byte that ends a frame waits for the serial 20-bit channel divide;
// the sample is then presented and held until the output takes it.
// Throughput: one byte per cycle outside frame ends and end of file; one item in flight.
// On end of file a status result is presented; state clears when it is taken.
// Reset: asynchronous, active low; returns to expecting the RIFF header.
// ----------------------------------------------------------------------------
module wav_pcm16_parse_downmix_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_file,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [15:0] mono_sample,
    output logic [1:0]         load_status,
    output logic               last
);
    import wpd_pkg::*;

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic signed [15:0] mean;
    logic [1:0]         status;
    logic               kind;

    wpd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_eof    (end_of_file),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (kind),
        .out_last  (last),
        .cmd       (cmd),
        .sts       (sts)
    );

    wpd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .data_byte (data_byte),
        .mean      (mean),
        .status    (status)
    );

    assign result_kind = kind;
    assign mono_sample = (kind == KIND_SAMPLE) ? mean : 16'sd0;
    assign load_status = (kind == KIND_STATUS) ? status : ST_CD;

endmodule
